// File: src/tpcs_pkg.sv
// Shared constants for the tilt to palette color slew block.
`timescale 1ns / 1ps
`default_nettype none

package tpcs_pkg;

    localparam int AXIS_W        = 16;
    localparam int COLOR_W       = 8;
    localparam int RGB_W         = 3 * COLOR_W;
    localparam int SIZE_W        = 5;
    localparam int ENTRY_W       = 4;
    localparam int REQ_W         = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [REQ_W-1:0] REQ_SAMPLE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RETARGET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_HIGH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP    = 2'd3;

    localparam logic signed [AXIS_W-1:0] AXIS_LOW_RESET  = -16'sd4000;
    localparam logic signed [AXIS_W-1:0] AXIS_HIGH_RESET = 16'sd4000;
    localparam logic [SIZE_W-1:0]        SIZE_RESET      = 5'd16;
    localparam logic [COLOR_W-1:0]       STEP_RESET      = 8'd1;

endpackage

`default_nettype wire

// File: src/tilt_to_palette_color_slew.sv
// Top level: tilt sample to palette color with per-sample slew limit.
//
// Input channel: in_valid / in_stall carry one request (sample, palette
// write or retarget). Output channel: out_valid / out_stall carry one color
// result per tilt sample. Configuration: cfg_valid / cfg_ready writes the
// axis window, palette size and slew step; cfg_ready is always high.
// A palette write or retarget request gives no result. A tilt sample
// passes through clamp, multiply, a bit-serial divide of one quotient bit
// per cycle, a palette read and the slew step.
// in_stall stays high while a sample is in work.
// The result sits in an output register; the next request is accepted while
// it waits. When out_stall holds a result, a following sample finishes its
// work and then waits until the register frees.
// Reset clears the shown and target colors, forces a target reload on the
// first sample and loads the default configuration. Palette entries are
// undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module tilt_to_palette_color_slew #(
    parameter int PALETTE_DEPTH = tpcs_pkg::DEPTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [tpcs_pkg::REQ_W-1:0]        req_type,
    input  wire logic signed [tpcs_pkg::AXIS_W-1:0] axis_value,
    input  wire logic [tpcs_pkg::ENTRY_W-1:0]      entry_index,
    input  wire logic [tpcs_pkg::COLOR_W-1:0]      entry_red,
    input  wire logic [tpcs_pkg::COLOR_W-1:0]      entry_green,
    input  wire logic [tpcs_pkg::COLOR_W-1:0]      entry_blue,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [tpcs_pkg::COLOR_W-1:0]           out_red,
    output logic [tpcs_pkg::COLOR_W-1:0]           out_green,
    output logic [tpcs_pkg::COLOR_W-1:0]           out_blue,
    output logic [tpcs_pkg::ENTRY_W-1:0]           chosen_index,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tpcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tpcs_pkg::AXIS_W-1:0]       cfg_data
);
    import tpcs_pkg::*;

    localparam int QW = $clog2(PALETTE_DEPTH);
    localparam int PW = AXIS_W + 1 + QW;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLAMP = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_SLEW  = 3'd6;

    function automatic logic [COLOR_W-1:0] slew(
        input logic [COLOR_W-1:0] cur,
        input logic [COLOR_W-1:0] goal,
        input logic [COLOR_W-1:0] step
    );
        logic [COLOR_W-1:0] res;
        res = cur;
        if (cur > goal)
        begin
            res = ((cur - goal) > step) ? cur - step : goal;
        end
        else if (cur < goal)
        begin
            res = ((goal - cur) > step) ? cur + step : goal;
        end
        return res;
    endfunction

    logic [2:0] state_reg, state_next;

    logic signed [AXIS_W-1:0] low_reg, high_reg;
    logic [SIZE_W-1:0]        size_reg;
    logic [COLOR_W-1:0]       step_reg;

    logic signed [AXIS_W-1:0] axis_reg;
    logic [AXIS_W:0]          off_reg, span_reg;
    logic [QW-1:0]            nm1_reg;
    logic [PW-1:0]            prod_reg;

    logic [RGB_W-1:0] shown_reg, goal_reg;
    logic [QW-1:0]    goal_idx_reg;
    logic             goal_valid_reg;

    logic                 out_valid_reg;
    logic [RGB_W-1:0]     out_rgb_reg;
    logic [ENTRY_W-1:0]   out_idx_reg;

    logic                 in_xfer;
    logic                 pal_we;
    logic [RGB_W-1:0]     pal_rdata;
    logic                 div_start, div_done;
    logic [QW-1:0]        div_q;
    logic                 reload;
    logic [RGB_W-1:0]     target;
    logic [RGB_W-1:0]     shown_new;
    logic                 out_free;
    logic signed [AXIS_W-1:0] clamped;
    logic signed [AXIS_W:0]   off_s, span_s;
    logic [QW-1:0]        nm1_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !(out_valid_reg && out_stall);

    assign pal_we = in_xfer && (req_type == REQ_WRITE) &&
                    (32'(entry_index) < PALETTE_DEPTH);

    tpcs_palette #(
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (QW'(entry_index)),
        .wdata ({entry_red, entry_green, entry_blue}),
        .re    (state_reg == ST_READ),
        .raddr (div_q),
        .rdata (pal_rdata)
    );

    assign div_start = (state_reg == ST_DIV);

    tpcs_div #(
        .QW (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        if (axis_reg < low_reg)
        begin
            clamped = low_reg;
        end
        else if (axis_reg > high_reg)
        begin
            clamped = high_reg;
        end
        else
        begin
            clamped = axis_reg;
        end
        off_s  = $signed({clamped[AXIS_W-1], clamped}) -
                 $signed({low_reg[AXIS_W-1], low_reg});
        span_s = $signed({high_reg[AXIS_W-1], high_reg}) -
                 $signed({low_reg[AXIS_W-1], low_reg});
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            nm1_next = '0;
        end
        else if (32'(size_reg) > PALETTE_DEPTH)
        begin
            nm1_next = QW'(PALETTE_DEPTH - 1);
        end
        else
        begin
            nm1_next = QW'(size_reg - 1'b1);
        end
    end

    assign reload = !goal_valid_reg || (div_q != goal_idx_reg);
    assign target = reload ? pal_rdata : goal_reg;
    assign shown_new = {
        slew(shown_reg[RGB_W-1 -: COLOR_W], target[RGB_W-1 -: COLOR_W], step_reg),
        slew(shown_reg[2*COLOR_W-1 -: COLOR_W], target[2*COLOR_W-1 -: COLOR_W], step_reg),
        slew(shown_reg[COLOR_W-1:0], target[COLOR_W-1:0], step_reg)
    };

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (req_type == REQ_SAMPLE))
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: state_next = ST_MUL;
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_SLEW;
            ST_SLEW:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_reg        <= AXIS_LOW_RESET;
            high_reg       <= AXIS_HIGH_RESET;
            size_reg       <= SIZE_RESET;
            step_reg       <= STEP_RESET;
            shown_reg      <= '0;
            goal_reg       <= '0;
            goal_idx_reg   <= '0;
            goal_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_AXIS_LOW:     low_reg  <= $signed(cfg_data);
                    CFG_AXIS_HIGH:    high_reg <= $signed(cfg_data);
                    CFG_PALETTE_SIZE: size_reg <= cfg_data[SIZE_W-1:0];
                    CFG_SLEW_STEP:    step_reg <= cfg_data[COLOR_W-1:0];
                    default:          ;
                endcase
            end
            if (in_xfer && (req_type == REQ_RETARGET))
            begin
                goal_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_SLEW) && out_free)
            begin
                if (reload)
                begin
                    goal_reg       <= pal_rdata;
                    goal_idx_reg   <= div_q;
                    goal_valid_reg <= 1'b1;
                end
                shown_reg     <= shown_new;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            axis_reg <= axis_value;
        end
        if (state_reg == ST_CLAMP)
        begin
            nm1_reg <= nm1_next;
            if (high_reg <= low_reg)
            begin
                off_reg  <= '0;
                span_reg <= (AXIS_W+1)'(1);
            end
            else
            begin
                off_reg  <= off_s;
                span_reg <= span_s;
            end
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PW'(off_reg) * PW'(nm1_reg);
        end
        if ((state_reg == ST_SLEW) && out_free)
        begin
            out_rgb_reg <= shown_new;
            out_idx_reg <= ENTRY_W'(div_q);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_red      = out_rgb_reg[RGB_W-1 -: COLOR_W];
    assign out_green    = out_rgb_reg[2*COLOR_W-1 -: COLOR_W];
    assign out_blue     = out_rgb_reg[COLOR_W-1:0];
    assign chosen_index = out_idx_reg;

endmodule

`default_nettype wire

// File: src/tpcs_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tpcs_div #(
    parameter int QW = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [tpcs_pkg::AXIS_W+QW:0] dividend,
    input  wire logic [tpcs_pkg::AXIS_W:0]    divisor,
    output logic                        done,
    output logic [QW-1:0]               quotient
);
    import tpcs_pkg::*;

    localparam int PW = AXIS_W + 1 + QW;
    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic [PW-1:0] rem_reg, rem_next;
    logic [PW-1:0] dsr_reg, dsr_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          fits;

    assign fits = (rem_reg >= dsr_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dsr_next  = PW'(divisor) << (QW - 1);
            q_next    = '0;
            cnt_next  = CW'(QW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            q_next   = (q_reg << 1) | QW'(fits);
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// File: src/tpcs_palette.sv
// Palette color store with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tpcs_palette #(
    parameter int DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [tpcs_pkg::RGB_W-1:0]   wdata,
    input  wire logic                         re,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [tpcs_pkg::RGB_W-1:0]        rdata
);
    import tpcs_pkg::*;

    logic [RGB_W-1:0] mem [DEPTH];
    logic [RGB_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
